/* sv/rmbp_pkg.sv */
// shared constants for the region mask brush painter
`default_nettype none

package rmbp_pkg;

  // command codes
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_PAINT = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // configuration register indexes
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 9;
  localparam logic [CFG_INDEX_W-1:0] CFG_MASK_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MASK_HEIGHT = 1'd1;
  localparam logic [CFG_DATA_W-1:0]  MASK_SIZE_RESET = 9'd256;

  // mask storage word
  localparam int WORD_BITS = 32;
  localparam int BIT_SEL_W = $clog2(WORD_BITS);

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

endpackage

`default_nettype wire

/* sv/rmbp_if.sv */
// command and result channel interfaces
`default_nettype none

interface rmbp_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic               shape_is_circle;
  logic signed [15:0] rect_left;
  logic signed [15:0] rect_top;
  logic [14:0]        rect_span_x;
  logic [14:0]        rect_span_y;
  logic signed [15:0] centre_x;
  logic signed [15:0] centre_y;
  logic [14:0]        radius;
  logic [7:0]         probe_x;
  logic [7:0]         probe_y;

  modport source (
    output valid, command, shape_is_circle, rect_left, rect_top, rect_span_x, rect_span_y,
           centre_x, centre_y, radius, probe_x, probe_y,
    input  ready
  );
  modport sink (
    input  valid, command, shape_is_circle, rect_left, rect_top, rect_span_x, rect_span_y,
           centre_x, centre_y, radius, probe_x, probe_y,
    output ready
  );
endinterface

interface rmbp_res_if;
  logic valid;
  logic ready;
  logic pixel_value;
  logic command_done;

  modport source (output valid, pixel_value, command_done, input ready);
  modport sink (input valid, pixel_value, command_done, output ready);
endinterface

`default_nettype wire

/* sv/region_mask_brush_painter.sv */
// region mask brush painter: one-bit mask with clear, rectangle/circle paint and pixel read
// usage:
//   cmd carries one command per transaction (clear, paint brush, read pixel); res returns
//   exactly one transaction per command, with pixel_value set only for reads.
//   mask_width and mask_height are written through the cfg port while the block is idle.
// the mask sits in one synchronous ram of 32-bit words, one row of the mask per
// 2**CW words; a paint runs read-modify-write a word at a time, one pixel per cycle.
// states per command, from acceptance to the result register:
//   read: ram read on acceptance, S_READ picks the bit, then S_DONE
//   paint: S_SETUP1 to S_SETUP4, S_PAINT over the clipped bounding box, then S_DONE
//          (an empty or clipped-away brush goes from S_SETUP1 straight to S_DONE)
//   clear: S_CLEAR zeroes one ram word per cycle over the whole ram, then S_DONE
//   unused command: straight to S_DONE
// the pixel walk of a paint sets the throughput; one command is worked on at a time.
// after reset the same clearing sweep zeroes all MAX_HEIGHT * 2**CW words (2048 by default)
// with cmd.ready low; cfg writes are taken throughout.
// a finished result waits in the output register while res.ready is low; the next
// command is still accepted and is held back only when its own result is due.
`default_nettype none

module region_mask_brush_painter #(
  parameter int MAX_WIDTH  = rmbp_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rmbp_pkg::DEF_MAX_HEIGHT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [rmbp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rmbp_pkg::CFG_DATA_W-1:0]  cfg_data,
  rmbp_cmd_if.sink                         cmd,
  rmbp_res_if.source                       res
);

  localparam int WB    = rmbp_pkg::WORD_BITS;
  localparam int SW    = rmbp_pkg::BIT_SEL_W;
  localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CW    = (XW > SW) ? XW - SW : 1;
  localparam int XP    = CW + SW;
  localparam int DEPTH = MAX_HEIGHT * (1 << CW);
  localparam int AW    = $clog2(DEPTH);
  localparam logic [12:0] MAXW = 13'(MAX_WIDTH);
  localparam logic [12:0] MAXH = 13'(MAX_HEIGHT);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SETUP1, S_SETUP2, S_SETUP3, S_SETUP4, S_PAINT, S_READ, S_DONE
  } state_t;

  state_t state;

  // configuration
  logic [8:0] mask_width;
  logic [8:0] mask_height;
  logic [8:0] eff_w;
  logic [8:0] eff_h;

  // captured command
  logic               shape;
  logic signed [15:0] l;
  logic signed [15:0] t;
  logic [14:0]        sx;
  logic [14:0]        sy;
  logic signed [15:0] cx;
  logic signed [15:0] cy;
  logic [14:0]        r;
  logic [SW-1:0]      probe_bit;
  logic               probe_in;

  // paint walk
  logic [XW-1:0]      x0, x1, x;
  logic [YW-1:0]      y0, y1, y;
  logic [29:0]        r2;
  logic signed [16:0] dx0, dx, dy;
  logic [31:0]        dx0sq, dysq, rb, d;
  logic [WB-1:0]      acc;
  logic               wr_pend;
  logic [AW-1:0]      wr_addr;
  logic [WB-1:0]      wr_mask;

  // clearing sweep
  logic [AW-1:0] clr_addr;
  logic          clr_reply;

  // result
  logic pix;
  logic res_valid;
  logic res_pixel;

  // ram
  logic [WB-1:0] mem [DEPTH];
  logic [WB-1:0] mem_q;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [WB-1:0] mem_wdata;

  logic cmd_acc;

  // clipping
  logic signed [17:0] cx18, cy18, r18;
  logic signed [17:0] lo_x, hi_x, lo_y, hi_y, w_m1, h_m1;
  logic signed [17:0] x0_s, x1_s, y0_s, y1_s;
  logic               empty;

  // squares
  logic signed [33:0] dxsq_full, dysq_full;

  // per-pixel signals
  logic [XP-1:0] x_ext;
  logic [SW-1:0] bitn;
  logic [AW-1:0] pix_addr;
  logic          hit;
  logic [WB-1:0] hit_vec;
  logic          first;
  logic          last;
  logic [WB-1:0] acc_new;
  logic [31:0]   step_x, step_y, rb_next;

  // probe
  logic [XP-1:0] px_ext;
  logic [YW-1:0] py_t;
  logic [AW-1:0] probe_addr;
  logic          probe_ok;

  assign eff_w = ({4'b0, mask_width} > MAXW) ? 9'(MAX_WIDTH) : mask_width;
  assign eff_h = ({4'b0, mask_height} > MAXH) ? 9'(MAX_HEIGHT) : mask_height;

  assign cmd.ready        = (state == S_IDLE);
  assign cmd_acc          = cmd.valid && cmd.ready;
  assign res.valid        = res_valid;
  assign res.pixel_value  = res_pixel;
  assign res.command_done = 1'b1;

  // brush bounding box clipped to the mask
  always_comb begin
    cx18 = 18'(cx);
    cy18 = 18'(cy);
    r18  = $signed({3'b000, r});
    if (shape) begin
      lo_x = cx18 - r18;
      hi_x = cx18 + r18;
      lo_y = cy18 - r18;
      hi_y = cy18 + r18;
    end else begin
      lo_x = 18'(l);
      hi_x = 18'(l) + $signed({3'b000, sx}) - 18'sd1;
      lo_y = 18'(t);
      hi_y = 18'(t) + $signed({3'b000, sy}) - 18'sd1;
    end
    w_m1 = $signed({9'b0, eff_w}) - 18'sd1;
    h_m1 = $signed({9'b0, eff_h}) - 18'sd1;
    x0_s = (lo_x < 18'sd0) ? 18'sd0 : lo_x;
    y0_s = (lo_y < 18'sd0) ? 18'sd0 : lo_y;
    x1_s = (hi_x > w_m1) ? w_m1 : hi_x;
    y1_s = (hi_y > h_m1) ? h_m1 : hi_y;
    empty = (eff_w == 9'd0) || (eff_h == 9'd0) || (x0_s > x1_s) || (y0_s > y1_s);
  end

  assign dxsq_full = dx0 * dx0;
  assign dysq_full = dy * dy;

  // current pixel and its word
  always_comb begin
    x_ext    = XP'(x);
    bitn     = x_ext[SW-1:0];
    pix_addr = AW'({y, x_ext[XP-1:SW]});
    hit      = !shape || (d <= {2'b00, r2});
    hit_vec  = WB'(hit) << bitn;
    first    = (x == x0) || (bitn == '0);
    last     = (x == x1) || (bitn == SW'(WB - 1));
    acc_new  = first ? hit_vec : (acc | hit_vec);
    step_x   = 32'($signed({dx, 1'b1}));
    step_y   = 32'($signed({dy, 1'b1}));
    rb_next  = rb + step_y;
  end

  always_comb begin
    px_ext     = XP'(cmd.probe_x);
    py_t       = YW'(cmd.probe_y);
    probe_addr = AW'({py_t, px_ext[XP-1:SW]});
    probe_ok   = ({1'b0, cmd.probe_x} < eff_w) && ({1'b0, cmd.probe_y} < eff_h);
  end

  // ram ports
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = pix_addr;
    if (cmd_acc && (cmd.command == rmbp_pkg::CMD_READ)) begin
      mem_re    = 1'b1;
      mem_raddr = probe_addr;
    end else if ((state == S_PAINT) && first) begin
      mem_re = 1'b1;
    end
    // a word is written back the cycle after its last pixel, while q still holds it
    mem_we    = (state == S_CLEAR) || wr_pend;
    mem_waddr = (state == S_CLEAR) ? clr_addr : wr_addr;
    mem_wdata = (state == S_CLEAR) ? '0 : (mem_q | wr_mask);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mask_width  <= rmbp_pkg::MASK_SIZE_RESET;
      mask_height <= rmbp_pkg::MASK_SIZE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        rmbp_pkg::CFG_MASK_WIDTH:  mask_width  <= cfg_data;
        rmbp_pkg::CFG_MASK_HEIGHT: mask_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd_acc) begin
      shape     <= cmd.shape_is_circle;
      l         <= cmd.rect_left;
      t         <= cmd.rect_top;
      sx        <= cmd.rect_span_x;
      sy        <= cmd.rect_span_y;
      cx        <= cmd.centre_x;
      cy        <= cmd.centre_y;
      r         <= cmd.radius;
      probe_bit <= px_ext[SW-1:0];
      probe_in  <= probe_ok;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      clr_reply <= 1'b0;
      wr_pend   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      wr_pend <= (state == S_PAINT) && last;
      if (res_valid && res.ready && (state != S_DONE)) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (clr_addr == AW'(DEPTH - 1)) begin
            clr_addr <= '0;
            pix      <= 1'b0;
            state    <= clr_reply ? S_DONE : S_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (cmd_acc) begin
            pix <= 1'b0;
            case (cmd.command)
              rmbp_pkg::CMD_CLEAR: begin
                clr_reply <= 1'b1;
                state     <= S_CLEAR;
              end
              rmbp_pkg::CMD_PAINT: state <= S_SETUP1;
              rmbp_pkg::CMD_READ:  state <= S_READ;
              default:             state <= S_DONE;
            endcase
          end
        end
        S_SETUP1: begin
          x0 <= x0_s[XW-1:0];
          x1 <= x1_s[XW-1:0];
          y0 <= y0_s[YW-1:0];
          y1 <= y1_s[YW-1:0];
          r2 <= {15'b0, r} * {15'b0, r};
          state <= empty ? S_DONE : S_SETUP2;
        end
        S_SETUP2: begin
          dx0   <= 17'($signed(18'(x0)) - cx18);
          dy    <= 17'($signed(18'(y0)) - cy18);
          state <= S_SETUP3;
        end
        S_SETUP3: begin
          dx0sq <= dxsq_full[31:0];
          dysq  <= dysq_full[31:0];
          state <= S_SETUP4;
        end
        S_SETUP4: begin
          rb    <= dx0sq + dysq;
          d     <= dx0sq + dysq;
          x     <= x0;
          y     <= y0;
          dx    <= dx0;
          state <= S_PAINT;
        end
        S_PAINT: begin
          acc <= acc_new;
          if (last) begin
            wr_addr <= pix_addr;
            wr_mask <= acc_new;
          end
          if (x == x1) begin
            if (y == y1) begin
              state <= S_DONE;
            end else begin
              y  <= y + 1'b1;
              x  <= x0;
              dx <= dx0;
              dy <= dy + 17'sd1;
              rb <= rb_next;
              d  <= rb_next;
            end
          end else begin
            x  <= x + 1'b1;
            dx <= dx + 17'sd1;
            d  <= d + step_x;
          end
        end
        S_READ: begin
          pix   <= probe_in & mem_q[probe_bit];
          state <= S_DONE;
        end
        S_DONE: begin
          if (!res_valid || res.ready) begin
            res_valid <= 1'b1;
            res_pixel <= pix;
            clr_reply <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// self-checking testbench for the region mask brush painter
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         STALL_LIMIT = 300000;

  typedef struct {
    logic [1:0]         command;
    logic               shape_is_circle;
    logic signed [15:0] rect_left;
    logic signed [15:0] rect_top;
    logic [14:0]        rect_span_x;
    logic [14:0]        rect_span_y;
    logic signed [15:0] centre_x;
    logic signed [15:0] centre_y;
    logic [14:0]        radius;
    logic [7:0]         probe_x;
    logic [7:0]         probe_y;
  } brush_command_t;

  typedef struct {
    logic pixel_value;
    logic command_done;
  } mask_result_t;

  logic                             clk;
  logic                             rst;
  logic                             cfg_write;
  logic [rmbp_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [rmbp_pkg::CFG_DATA_W-1:0]  cfg_data;

  rmbp_cmd_if cmd_ch ();
  rmbp_res_if res_ch ();

  region_mask_brush_painter u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd_ch),
    .res       (res_ch)
  );

  // predicted mask contents and size registers
  bit mask_image [rmbp_pkg::DEF_MAX_WIDTH * rmbp_pkg::DEF_MAX_HEIGHT];
  logic [rmbp_pkg::CFG_DATA_W-1:0] mask_cols = rmbp_pkg::MASK_SIZE_RESET;
  logic [rmbp_pkg::CFG_DATA_W-1:0] mask_rows = rmbp_pkg::MASK_SIZE_RESET;

  mask_result_t pending_results [$];
  int           mismatch_count  = 0;
  bit           no_idle         = 1'b0;
  int unsigned  hold_off_cycles = 0;
  int           hot_x           = 128;
  int           hot_y           = 128;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint active_cols();
    return (mask_cols > rmbp_pkg::DEF_MAX_WIDTH) ? longint'(rmbp_pkg::DEF_MAX_WIDTH)
                                                 : longint'(mask_cols);
  endfunction

  function automatic longint active_rows();
    return (mask_rows > rmbp_pkg::DEF_MAX_HEIGHT) ? longint'(rmbp_pkg::DEF_MAX_HEIGHT)
                                                  : longint'(mask_rows);
  endfunction

  // bounding box of the brush clipped to the mask, false when nothing is left
  function automatic bit clipped_box(input brush_command_t c,
                                     output longint x0, y0, x1, y1);
    longint lo_x, lo_y, hi_x, hi_y, r;
    x0 = 0;
    y0 = 0;
    x1 = -1;
    y1 = -1;
    if (active_cols() == 0 || active_rows() == 0) return 1'b0;
    if (c.shape_is_circle) begin
      r    = longint'(c.radius);
      lo_x = longint'(c.centre_x) - r;
      hi_x = longint'(c.centre_x) + r;
      lo_y = longint'(c.centre_y) - r;
      hi_y = longint'(c.centre_y) + r;
    end else begin
      lo_x = longint'(c.rect_left);
      lo_y = longint'(c.rect_top);
      hi_x = lo_x + longint'(c.rect_span_x) - 1;
      hi_y = lo_y + longint'(c.rect_span_y) - 1;
    end
    x0 = (lo_x < 0) ? 0 : lo_x;
    y0 = (lo_y < 0) ? 0 : lo_y;
    x1 = (hi_x > active_cols() - 1) ? active_cols() - 1 : hi_x;
    y1 = (hi_y > active_rows() - 1) ? active_rows() - 1 : hi_y;
    return (x0 <= x1) && (y0 <= y1);
  endfunction

  // applies one command to the predicted mask and returns the pixel it reports
  function automatic logic run_mask_command(input brush_command_t c);
    longint x0, y0, x1, y1, x, y, dx, dy, r2;
    logic   pixel;
    pixel = 1'b0;
    case (c.command)
      rmbp_pkg::CMD_CLEAR: begin
        foreach (mask_image[i]) mask_image[i] = 1'b0;
      end
      rmbp_pkg::CMD_PAINT: begin
        if (clipped_box(c, x0, y0, x1, y1)) begin
          r2 = longint'(c.radius) * longint'(c.radius);
          for (y = y0; y <= y1; y++) begin
            for (x = x0; x <= x1; x++) begin
              dx = x - longint'(c.centre_x);
              dy = y - longint'(c.centre_y);
              if (!c.shape_is_circle || dx * dx + dy * dy <= r2)
                mask_image[y * rmbp_pkg::DEF_MAX_WIDTH + x] = 1'b1;
            end
          end
        end
      end
      rmbp_pkg::CMD_READ: begin
        if (longint'(c.probe_x) < active_cols() && longint'(c.probe_y) < active_rows())
          pixel = mask_image[int'(c.probe_y) * rmbp_pkg::DEF_MAX_WIDTH + int'(c.probe_x)];
      end
      default: ;
    endcase
    return pixel;
  endfunction

  function automatic brush_command_t rect_brush(input int l, t, sx, sy);
    brush_command_t c = '{default: '0};
    c.command     = rmbp_pkg::CMD_PAINT;
    c.rect_left   = 16'(l);
    c.rect_top    = 16'(t);
    c.rect_span_x = 15'(sx);
    c.rect_span_y = 15'(sy);
    return c;
  endfunction

  function automatic brush_command_t circle_brush(input int cx, cy, r);
    brush_command_t c = '{default: '0};
    c.command         = rmbp_pkg::CMD_PAINT;
    c.shape_is_circle = 1'b1;
    c.centre_x        = 16'(cx);
    c.centre_y        = 16'(cy);
    c.radius          = 15'(r);
    return c;
  endfunction

  function automatic brush_command_t pixel_read(input int x, y);
    brush_command_t c = '{default: '0};
    c.command = rmbp_pkg::CMD_READ;
    c.probe_x = 8'(x);
    c.probe_y = 8'(y);
    return c;
  endfunction

  function automatic brush_command_t bare_command(input logic [1:0] op);
    brush_command_t c = '{default: '0};
    c.command = op;
    return c;
  endfunction

  // coordinate in a band a little wider than the mask on both sides
  function automatic logic signed [15:0] near_coord(input longint extent);
    int v;
    v = int'($urandom_range(0, 32'(extent) + 16)) - 8;
    return v[15:0];
  endfunction

  function automatic logic [7:0] near_hot(input int centre);
    int v;
    v = centre + int'($urandom_range(0, 12)) - 6;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // mostly brushes that touch the mask and reads around the last brush
  function automatic brush_command_t random_command(input longint pixel_budget);
    brush_command_t c;
    int unsigned    pick;
    longint         x0, y0, x1, y1, area;
    do begin
      c.command         = rmbp_pkg::CMD_READ;
      c.shape_is_circle = 1'($urandom);
      c.rect_left       = 16'($urandom);
      c.rect_top        = 16'($urandom);
      c.rect_span_x     = 15'($urandom);
      c.rect_span_y     = 15'($urandom);
      c.centre_x        = 16'($urandom);
      c.centre_y        = 16'($urandom);
      c.radius          = 15'($urandom);
      c.probe_x         = 8'($urandom);
      c.probe_y         = 8'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        c.command = rmbp_pkg::CMD_CLEAR;
      end else if (pick < 5) begin
        c.command = CMD_UNUSED;
      end else if (pick < 52) begin
        c.command = rmbp_pkg::CMD_PAINT;
        if ($urandom_range(0, 99) >= 15) c.rect_left = near_coord(active_cols());
        if ($urandom_range(0, 99) >= 15) c.rect_top = near_coord(active_rows());
        if ($urandom_range(0, 99) >= 15) c.centre_x = near_coord(active_cols());
        if ($urandom_range(0, 99) >= 15) c.centre_y = near_coord(active_rows());
        if ($urandom_range(0, 99) >= 15) c.rect_span_x = 15'($urandom_range(0, 12));
        if ($urandom_range(0, 99) >= 15) c.rect_span_y = 15'($urandom_range(0, 12));
        if ($urandom_range(0, 99) >= 10) c.radius = 15'($urandom_range(0, 8));
      end else if ($urandom_range(0, 9) < 6) begin
        c.probe_x = near_hot(hot_x);
        c.probe_y = near_hot(hot_y);
      end
      area = 0;
      if (c.command == rmbp_pkg::CMD_PAINT && clipped_box(c, x0, y0, x1, y1))
        area = (x1 - x0 + 1) * (y1 - y0 + 1);
    end while (area > pixel_budget);
    if (area != 0) begin
      hot_x = int'((x0 + x1) / 2);
      hot_y = int'((y0 + y1) / 2);
    end
    return c;
  endfunction

  task automatic send_command(input brush_command_t c);
    int unsigned  gap;
    mask_result_t r;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    repeat (gap) begin
      @(negedge clk);
      cmd_ch.valid <= 1'b0;
    end
    @(negedge clk);
    cmd_ch.valid           <= 1'b1;
    cmd_ch.command         <= c.command;
    cmd_ch.shape_is_circle <= c.shape_is_circle;
    cmd_ch.rect_left       <= c.rect_left;
    cmd_ch.rect_top        <= c.rect_top;
    cmd_ch.rect_span_x     <= c.rect_span_x;
    cmd_ch.rect_span_y     <= c.rect_span_y;
    cmd_ch.centre_x        <= c.centre_x;
    cmd_ch.centre_y        <= c.centre_y;
    cmd_ch.radius          <= c.radius;
    cmd_ch.probe_x         <= c.probe_x;
    cmd_ch.probe_y         <= c.probe_y;
    do @(posedge clk); while (!cmd_ch.ready);
    r.pixel_value  = run_mask_command(c);
    r.command_done = 1'b1;
    pending_results.push_back(r);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mask_size(input int cols, rows);
    wait_drained();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= rmbp_pkg::CFG_MASK_WIDTH;
    cfg_data  <= rmbp_pkg::CFG_DATA_W'(cols);
    @(negedge clk);
    cfg_index <= rmbp_pkg::CFG_MASK_HEIGHT;
    cfg_data  <= rmbp_pkg::CFG_DATA_W'(rows);
    @(negedge clk);
    cfg_write <= 1'b0;
    mask_cols = rmbp_pkg::CFG_DATA_W'(cols);
    mask_rows = rmbp_pkg::CFG_DATA_W'(rows);
  endtask

  task automatic test_rect_brush();
    send_command(pixel_read(0, 0));
    send_command(rect_brush(-32768, -32768, 32767, 32767)); // ends left of and above the mask
    send_command(rect_brush(32767, 32767, 32767, 32767));
    send_command(rect_brush(10, 20, 0, 5));
    send_command(rect_brush(250, 250, 100, 100));            // clipped at the far corner
    send_command(pixel_read(255, 255));
    send_command(rect_brush(-3, -2, 5, 4));
    send_command(pixel_read(1, 1));
    send_command(pixel_read(2, 1));
  endtask

  task automatic test_circle_brush();
    send_command(circle_brush(100, 100, 0));                 // centre pixel only
    send_command(pixel_read(100, 100));
    send_command(pixel_read(101, 100));
    send_command(circle_brush(-32768, -32768, 32767));
    send_command(circle_brush(40, 200, 6));
    send_command(pixel_read(44, 204));
    send_command(pixel_read(45, 204));
    send_command(bare_command(CMD_UNUSED));
    send_command(bare_command(rmbp_pkg::CMD_CLEAR));
    send_command(pixel_read(255, 255));
  endtask

  task automatic test_mask_size();
    write_mask_size(0, 256);
    send_command(rect_brush(0, 0, 10, 10));
    send_command(pixel_read(0, 0));
    write_mask_size(256, 256);
    send_command(rect_brush(100, 100, 3, 3));
    // shrink then regrow without a clear: the old bits come back
    write_mask_size(50, 256);
    send_command(pixel_read(101, 101));
    write_mask_size(256, 256);
    send_command(pixel_read(101, 101));
    write_mask_size(16, 16);
    send_command(circle_brush(0, 0, 32767));
    send_command(pixel_read(15, 15));
  endtask

  task automatic test_random_traffic(input int count, input longint pixel_budget);
    repeat (count) send_command(random_command(pixel_budget));
  endtask

  // result side holds off while commands keep coming, so the input stalls
  task automatic test_backpressure();
    hold_off_cycles = 3000;
    no_idle         = 1'b1;
    test_random_traffic(40, 150);
    no_idle         = 1'b0;
  endtask

  initial begin : result_receiver
    int unsigned stall;
    res_ch.ready = 1'b0;
    forever begin
      if (hold_off_cycles != 0) begin
        stall           = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 9);
      end
      repeat (stall) begin
        @(negedge clk);
        res_ch.ready <= 1'b0;
      end
      @(negedge clk);
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (res_ch.valid !== 1'b1);
    end
  end

  function automatic void report_mismatch(input string what, input mask_result_t exp_r,
                                          input logic got_pixel, got_done);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch (%s): expected pixel_value=%0b command_done=%0b, got %0b %0b",
               what, exp_r.pixel_value, exp_r.command_done, got_pixel, got_done);
  endfunction

  always @(posedge clk) begin : result_check
    mask_result_t exp_r;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        exp_r = '{pixel_value: 1'bx, command_done: 1'bx};
        report_mismatch("unexpected transaction", exp_r, res_ch.pixel_value,
                        res_ch.command_done);
      end else begin
        exp_r = pending_results.pop_front();
        if (res_ch.pixel_value !== exp_r.pixel_value ||
            res_ch.command_done !== exp_r.command_done)
          report_mismatch("result field", exp_r, res_ch.pixel_value, res_ch.command_done);
      end
    end
  end

  // cycles without any transaction on either channel
  initial begin : stall_watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    rst                    = 1'b1;
    cfg_write              = 1'b0;
    cfg_index              = rmbp_pkg::CFG_MASK_WIDTH;
    cfg_data               = '0;
    cmd_ch.valid           = 1'b0;
    cmd_ch.command         = rmbp_pkg::CMD_CLEAR;
    cmd_ch.shape_is_circle = 1'b0;
    cmd_ch.rect_left       = '0;
    cmd_ch.rect_top        = '0;
    cmd_ch.rect_span_x     = '0;
    cmd_ch.rect_span_y     = '0;
    cmd_ch.centre_x        = '0;
    cmd_ch.centre_y        = '0;
    cmd_ch.radius          = '0;
    cmd_ch.probe_x         = '0;
    cmd_ch.probe_y         = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    test_rect_brush();
    test_circle_brush();
    test_mask_size();

    write_mask_size(256, 256);
    test_random_traffic(130, 300);
    write_mask_size(40, 24);
    no_idle = 1'b1;
    test_random_traffic(40, 1000);
    no_idle = 1'b0;
    test_random_traffic(100, 1000);
    test_backpressure();
    write_mask_size(511, 12);   // width saturates to the full mask
    test_random_traffic(80, 1200);
    write_mask_size(1, 256);
    test_random_traffic(40, 300);
    write_mask_size(0, 37);
    test_random_traffic(25, 300);
    write_mask_size(7, 3);
    test_random_traffic(50, 100);
    write_mask_size(256, 0);
    test_random_traffic(15, 300);
    write_mask_size(256, 256);
    test_random_traffic(40, 300);

    wait_drained();
    repeat (64) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule

/* files.f */
sv/rmbp_pkg.sv
sv/rmbp_if.sv
sv/region_mask_brush_painter.sv
tb/sv/testbench.sv
